// ----- rtl/core/rbspe_pkg.sv -----
package rbspe_pkg;

  // Default sizing of the point table and the basis
  localparam int MAX_POINTS_DEF = 16;
  localparam int MAX_DEGREE_DEF = 3;

  // Field widths
  localparam int COORD_W  = 24;
  localparam int WEIGHT_W = 16;
  localparam int U_W      = 17;
  localparam int PIDX_W   = 4;
  localparam int DEG_W    = 2;
  localparam int NPT_W    = 5;
  localparam int CFG_W    = 5;

  // Internal widths
  localparam int KIDX_W   = 8;   // knot index
  localparam int KNOT_W   = 5;   // knot value in units of one span
  localparam int US_W     = 22;  // u times span count
  localparam int NUM_W    = 18;  // clamped fraction numerator
  localparam int NB_W     = 31;  // basis value, Q.30
  localparam int PROD_W   = 49;
  localparam int WN_W     = 31;
  localparam int ACC_W    = 56;
  localparam int WSUM_W   = 32;
  localparam int DIV_N_W  = 57;
  localparam int DIV_D_W  = 33;
  localparam int DIV_Q_W  = 24;

  localparam logic [U_W-1:0]      U_ONE      = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd4096;
  localparam logic [NB_W-1:0]     BASIS_ONE  = 31'h4000_0000;
  localparam logic [33:0]         RECIP3     = 34'h0_AAAA_AAAB;

  // Register indexes
  localparam logic [0:0] REG_DEGREE = 1'b0;
  localparam logic [0:0] REG_COUNT  = 1'b1;

  // Request kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic [PIDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [WEIGHT_W-1:0]        point_weight;
    logic [U_W-1:0]             param_u;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  curve_x;
    logic signed [COORD_W-1:0]  curve_y;
    logic signed [COORD_W-1:0]  curve_z;
    logic                       eval_error;
  } out_res_t;

  typedef struct packed {
    logic accept_load;
    logic accept_eval;
    logic setup;
    logic init;
    logic frac_a;
    logic frac_b;
    logic frac_c;
    logic wrd;
    logic wm1;
    logic wm2;
    logic wacc;
    logic dchk;
    logic div_start;
    logic div_store;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_bad;
    logic deg_zero;
    logic step_last;
    logic level_last;
    logic pt_last;
    logic wsum_zero;
    logic div_done;
    logic coord_last;
  } dp_sts_t;

  // Clamped uniform knot j, in units of 1/s
  function automatic logic [KNOT_W-1:0] knot_at(logic [KIDX_W-1:0] j, logic [DEG_W-1:0] p,
                                                 logic [NPT_W-1:0] s);
    logic signed [KIDX_W+1:0] c;
    c = $signed({2'b00, j}) - $signed({{KIDX_W{1'b0}}, p});
    if (c < 0) return '0;
    else if (c > $signed({{(KIDX_W+2-NPT_W){1'b0}}, s})) return s;
    else return c[KNOT_W-1:0];
  endfunction

endpackage

// ----- rtl/core/rbspe_div.sv -----
module rbspe_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [rbspe_pkg::DIV_N_W-1:0]    num,
  input  logic [rbspe_pkg::DIV_D_W-1:0]    den,
  output logic                             done,
  output logic [rbspe_pkg::DIV_Q_W-1:0]    quot,
  output logic                             ovf
);

  localparam int NW = rbspe_pkg::DIV_N_W;
  localparam int DW = rbspe_pkg::DIV_D_W;
  localparam int QW = rbspe_pkg::DIV_Q_W;

  logic [NW-1:0]          rem_r;
  logic [NW-1:0]          dsh_r;
  logic [QW-1:0]          quot_r;
  logic [$clog2(QW)-1:0]  bit_r;
  logic                   run_r;
  logic                   done_r;
  logic                   ovf_r;
  logic                   ge;
  logic [NW-1:0]          den_top;

  assign ge      = rem_r >= dsh_r;
  assign den_top = {den, {QW{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (num >= den_top) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r && bit_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r  <= num >= den_top;
      rem_r  <= num;
      dsh_r  <= NW'({den, {(QW-1){1'b0}}});
      quot_r <= '0;
      bit_r  <= ($clog2(QW))'(QW-1);
    end else if (run_r) begin
      if (ge) rem_r <= rem_r - dsh_r;
      quot_r <= {quot_r[QW-2:0], ge};
      dsh_r  <= dsh_r >> 1;
      bit_r  <= bit_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign ovf  = ovf_r;

endmodule

// ----- rtl/core/rbspe_ctrl.sv -----
module rbspe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                kind,
  input  rbspe_pkg::dp_sts_t  sts,
  output rbspe_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_FA     = 4'd3;
  localparam logic [3:0] S_FB     = 4'd4;
  localparam logic [3:0] S_FC     = 4'd5;
  localparam logic [3:0] S_WRD    = 4'd6;
  localparam logic [3:0] S_WM1    = 4'd7;
  localparam logic [3:0] S_WM2    = 4'd8;
  localparam logic [3:0] S_WACC   = 4'd9;
  localparam logic [3:0] S_DCHK   = 4'd10;
  localparam logic [3:0] S_DSTART = 4'd11;
  localparam logic [3:0] S_DWAIT  = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (kind == rbspe_pkg::KIND_EVAL) begin
            cmd.accept_eval = 1'b1;
            state_nxt       = S_SETUP;
          end else begin
            cmd.accept_load = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init = 1'b1;
        if (sts.cfg_bad)       state_nxt = S_OUT;
        else if (sts.deg_zero) state_nxt = S_WRD;
        else                   state_nxt = S_FA;
      end
      S_FA: begin
        cmd.frac_a = 1'b1;
        state_nxt  = S_FB;
      end
      S_FB: begin
        cmd.frac_b = 1'b1;
        state_nxt  = S_FC;
      end
      S_FC: begin
        cmd.frac_c = 1'b1;
        if (sts.step_last && sts.level_last) state_nxt = S_WRD;
        else                                 state_nxt = S_FA;
      end
      S_WRD: begin
        cmd.wrd   = 1'b1;
        state_nxt = S_WM1;
      end
      S_WM1: begin
        cmd.wm1   = 1'b1;
        state_nxt = S_WM2;
      end
      S_WM2: begin
        cmd.wm2   = 1'b1;
        state_nxt = S_WACC;
      end
      S_WACC: begin
        cmd.wacc  = 1'b1;
        state_nxt = sts.pt_last ? S_DCHK : S_WRD;
      end
      S_DCHK: begin
        cmd.dchk  = 1'b1;
        state_nxt = sts.wsum_zero ? S_OUT : S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = sts.coord_last ? S_OUT : S_DSTART;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;

endmodule

// ----- rtl/core/rbspe_dp.sv -----
module rbspe_dp #(
  parameter int MAX_POINTS = rbspe_pkg::MAX_POINTS_DEF,
  parameter int MAX_DEGREE = rbspe_pkg::MAX_DEGREE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbspe_pkg::in_req_t            in_req,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [rbspe_pkg::CFG_W-1:0]   cfg_wdata,
  input  rbspe_pkg::dp_cmd_t            cmd,
  output rbspe_pkg::dp_sts_t            sts,
  output rbspe_pkg::out_res_t           out_res
);

  localparam int NB_LEN = MAX_POINTS + MAX_DEGREE;
  localparam int CNT_W  = $clog2(NB_LEN);
  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CW     = rbspe_pkg::COORD_W;
  localparam int KW     = rbspe_pkg::KNOT_W;
  localparam int KIW    = rbspe_pkg::KIDX_W;
  localparam int NBW    = rbspe_pkg::NB_W;

  // Configuration
  logic [rbspe_pkg::DEG_W-1:0] deg_r;
  logic [rbspe_pkg::NPT_W-1:0] npt_r;
  logic [rbspe_pkg::NPT_W-1:0] span_s;
  logic                        cfg_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 2'd3;
      npt_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        rbspe_pkg::REG_DEGREE: deg_r <= cfg_wdata[rbspe_pkg::DEG_W-1:0];
        rbspe_pkg::REG_COUNT:  npt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign span_s  = npt_r - {3'b000, deg_r};
  assign cfg_bad = ({1'b0, npt_r} < ({4'b0000, deg_r} + 6'd1)) || (npt_r < 5'd2) ||
                   (32'(npt_r) > MAX_POINTS) || (32'(deg_r) > MAX_DEGREE);

  // Point table
  logic signed [CW-1:0]               mem_x [MAX_POINTS];
  logic signed [CW-1:0]               mem_y [MAX_POINTS];
  logic signed [CW-1:0]               mem_z [MAX_POINTS];
  logic [rbspe_pkg::WEIGHT_W-1:0]     mem_w [MAX_POINTS];
  logic [MAX_POINTS-1:0]              w_vld_r;
  logic signed [CW-1:0]               rdx_r, rdy_r, rdz_r;
  logic [rbspe_pkg::WEIGHT_W-1:0]     rdw_r;
  logic                               rdv_r;
  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  logic [AW-1:0]                      rd_addr;
  logic [CNT_W-1:0]                   cnt_r;

  assign wr_en   = cmd.accept_load && (32'(in_req.point_index) < MAX_POINTS);
  assign wr_addr = AW'(in_req.point_index);
  assign rd_addr = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= in_req.coord_x;
      mem_y[wr_addr] <= in_req.coord_y;
      mem_z[wr_addr] <= in_req.coord_z;
      mem_w[wr_addr] <= in_req.point_weight;
    end
    if (cmd.wrd) begin
      rdx_r <= mem_x[rd_addr];
      rdy_r <= mem_y[rd_addr];
      rdz_r <= mem_z[rd_addr];
      rdw_r <= mem_w[rd_addr];
      rdv_r <= w_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)     w_vld_r <= '0;
    else if (wr_en) w_vld_r[wr_addr] <= 1'b1;
  end

  // Parameter
  logic [rbspe_pkg::U_W-1:0]  u_r;
  logic [rbspe_pkg::US_W-1:0] us_r;
  logic                       u_one;

  assign u_one = u_r == rbspe_pkg::U_ONE;

  always_ff @(posedge clk) begin
    if (cmd.accept_eval) begin
      u_r <= (in_req.param_u > rbspe_pkg::U_ONE) ? rbspe_pkg::U_ONE : in_req.param_u;
    end
    if (cmd.setup) begin
      us_r <= rbspe_pkg::US_W'({5'b0, u_r} * {17'b0, span_s});
    end
  end

  // Degree-zero spans
  logic [KW-1:0]     lo_k [NB_LEN];
  logic [KW-1:0]     hi_k [NB_LEN];
  logic [NB_LEN-1:0] span_on;

  always_comb begin
    for (int e = 0; e < NB_LEN; e++) begin
      lo_k[e]    = rbspe_pkg::knot_at(KIW'(e), deg_r, span_s);
      hi_k[e]    = rbspe_pkg::knot_at(KIW'(e + 1), deg_r, span_s);
      span_on[e] = (({1'b0, lo_k[e], 16'b0} <= us_r) && (us_r < {1'b0, hi_k[e], 16'b0})) ||
                   (u_one && (KIW'(e) == (KIW'(npt_r) - 8'd1)));
    end
  end

  // Recursion step: fractions of the two basis values at the head of the line
  logic [NBW-1:0]          nb_r [NB_LEN];
  logic [1:0]              lvl_r;
  logic [KIW-1:0]          ki;
  logic [KW-1:0]           ci, ck, ci1, ck1;
  logic [1:0]              dl, dr;
  logic signed [22:0]      numl_s, numr_s;
  logic [rbspe_pkg::NUM_W-1:0] denl, denr, numl_c, numr_c;
  logic [rbspe_pkg::PROD_W-1:0] prodl, prodr, prodl_r, prodr_r;
  logic [1:0]              dl_r, dr_r;
  logic [NBW-1:0]          ql_r, qr_r;

  function automatic logic [NBW-1:0] div_small(logic [31:0] y, logic [1:0] d);
    logic [65:0] m;
    m = {34'b0, y} * {32'b0, rbspe_pkg::RECIP3};
    case (d)
      2'd0:    return '0;
      2'd1:    return y[NBW-1:0];
      2'd2:    return y[31:1];
      default: return m[63:33];
    endcase
  endfunction

  assign ki  = KIW'(cnt_r);
  assign ci  = rbspe_pkg::knot_at(ki, deg_r, span_s);
  assign ck  = rbspe_pkg::knot_at(ki + KIW'(lvl_r), deg_r, span_s);
  assign ci1 = rbspe_pkg::knot_at(ki + 8'd1, deg_r, span_s);
  assign ck1 = rbspe_pkg::knot_at(ki + KIW'(lvl_r) + 8'd1, deg_r, span_s);
  assign dl  = 2'(ck - ci);
  assign dr  = 2'(ck1 - ci1);
  assign denl = {dl, 16'b0};
  assign denr = {dr, 16'b0};

  assign numl_s = $signed({1'b0, us_r}) - $signed({2'b00, ci, 16'b0});
  assign numr_s = $signed({2'b00, ck1, 16'b0}) - $signed({1'b0, us_r});

  // Clamp numerators to [0, den]
  always_comb begin
    if (numl_s < 0)                          numl_c = '0;
    else if (numl_s > $signed({5'b0, denl})) numl_c = denl;
    else                                     numl_c = numl_s[17:0];
    if (numr_s < 0)                          numr_c = '0;
    else if (numr_s > $signed({5'b0, denr})) numr_c = denr;
    else                                     numr_c = numr_s[17:0];
  end

  assign prodl = numl_c * nb_r[0];
  assign prodr = numr_c * nb_r[1];

  always_ff @(posedge clk) begin
    if (cmd.frac_a) begin
      prodl_r <= prodl;
      prodr_r <= prodr;
      dl_r    <= dl;
      dr_r    <= dr;
    end
    if (cmd.frac_b) begin
      ql_r <= div_small(prodl_r[47:16], dl_r);
      qr_r <= div_small(prodr_r[47:16], dr_r);
    end
  end

  // Basis shift line, step and level counters
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int e = 0; e < NB_LEN; e++) nb_r[e] <= span_on[e] ? rbspe_pkg::BASIS_ONE : '0;
    end else if (cmd.frac_c || cmd.wacc) begin
      for (int e = 0; e < NB_LEN - 1; e++) nb_r[e] <= nb_r[e + 1];
      nb_r[NB_LEN-1] <= cmd.frac_c ? ql_r + qr_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lvl_r <= 2'd1;
    end else if (cmd.init) begin
      cnt_r <= '0;
      lvl_r <= 2'd1;
    end else if (cmd.frac_c) begin
      if (sts.step_last) begin
        cnt_r <= '0;
        lvl_r <= lvl_r + 2'd1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (cmd.wacc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Weighted sums
  logic [rbspe_pkg::WEIGHT_W-1:0] w_eff;
  logic [46:0]                    wprod;
  logic [rbspe_pkg::WN_W-1:0]     wn_r;
  logic signed [rbspe_pkg::ACC_W-1:0] px_r, py_r, pz_r, ax_r, ay_r, az_r;
  logic [rbspe_pkg::WSUM_W-1:0]   wsum_r;

  assign w_eff = rdv_r ? rdw_r : rbspe_pkg::WEIGHT_ONE;
  assign wprod = w_eff * nb_r[0];

  always_ff @(posedge clk) begin
    if (cmd.wm1) wn_r <= wprod[46:16];
    if (cmd.wm2) begin
      px_r <= $signed({1'b0, wn_r}) * rdx_r;
      py_r <= $signed({1'b0, wn_r}) * rdy_r;
      pz_r <= $signed({1'b0, wn_r}) * rdz_r;
    end
    if (cmd.init) begin
      ax_r   <= '0;
      ay_r   <= '0;
      az_r   <= '0;
      wsum_r <= '0;
    end else if (cmd.wacc) begin
      ax_r   <= ax_r + px_r;
      ay_r   <= ay_r + py_r;
      az_r   <= az_r + pz_r;
      wsum_r <= wsum_r + {1'b0, wn_r};
    end
  end

  // Final division, one coordinate at a time
  logic [1:0]                        coord_r;
  logic signed [rbspe_pkg::ACC_W-1:0] sel;
  logic [rbspe_pkg::ACC_W-1:0]       mag;
  logic [rbspe_pkg::DIV_N_W-1:0]     div_n;
  logic [rbspe_pkg::DIV_D_W-1:0]     div_d;
  logic                              div_done;
  logic [rbspe_pkg::DIV_Q_W-1:0]     div_q;
  logic                              div_ovf;
  logic [24:0]                       qs;
  logic [CW-1:0]                     res;
  logic signed [CW-1:0]              res_x_r, res_y_r, res_z_r;
  logic                              err_r;

  always_comb begin
    case (coord_r)
      2'd0:    sel = ax_r;
      2'd1:    sel = ay_r;
      default: sel = az_r;
    endcase
  end

  assign mag   = sel[rbspe_pkg::ACC_W-1] ? rbspe_pkg::ACC_W'(-sel) : sel;
  assign div_n = {mag, 1'b0} + {25'b0, wsum_r};
  assign div_d = {wsum_r, 1'b0};

  rbspe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quot  (div_q),
    .ovf   (div_ovf)
  );

  // Saturate the magnitude to 2^23, then to the signed range
  always_comb begin
    if (div_ovf || ({1'b0, div_q} > 25'h80_0000)) qs = 25'h80_0000;
    else                                           qs = {1'b0, div_q};
    if (sel[rbspe_pkg::ACC_W-1]) res = CW'(25'd0 - qs);
    else if (qs[23])             res = 24'h7F_FFFF;
    else                         res = qs[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
    end else if (cmd.init) begin
      coord_r <= '0;
    end else if (cmd.div_store) begin
      coord_r <= coord_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      res_x_r <= '0;
      res_y_r <= '0;
      res_z_r <= '0;
      err_r   <= cfg_bad;
    end else begin
      if (cmd.dchk && sts.wsum_zero) err_r <= 1'b1;
      if (cmd.div_store) begin
        case (coord_r)
          2'd0:    res_x_r <= res;
          2'd1:    res_y_r <= res;
          default: res_z_r <= res;
        endcase
      end
    end
  end

  assign out_res.curve_x    = res_x_r;
  assign out_res.curve_y    = res_y_r;
  assign out_res.curve_z    = res_z_r;
  assign out_res.eval_error = err_r;

  assign sts.cfg_bad    = cfg_bad;
  assign sts.deg_zero   = deg_r == '0;
  assign sts.step_last  = cnt_r == CNT_W'(NB_LEN - 1);
  assign sts.level_last = lvl_r == deg_r;
  assign sts.pt_last    = KIW'(cnt_r) == (KIW'(npt_r) - 8'd1);
  assign sts.wsum_zero  = wsum_r == '0;
  assign sts.div_done   = div_done;
  assign sts.coord_last = coord_r == 2'd2;

endmodule

// ----- rtl/core/rational_bspline_point_eval.sv -----
// Channel   Ports                                Handshake
// --------  -----------------------------------  -------------------------------------
// request   start, busy, in_req                  taken at an edge with start=1, busy=0
// result    out_valid, out_res                   one-cycle strobe, cannot be held off
// config    cfg_we, cfg_index, cfg_wdata         written at an edge with cfg_we=1
//
// A load request writes the point table in the accept cycle and leaves busy low.
// An evaluate request runs from the accepting edge through the result strobe: the shared
// fraction unit walks the whole basis line once per level, each point is weighted in turn,
// and each coordinate passes through the bit-serial divider. A bad setup goes straight to
// the result strobe with eval_error set.
// Reset is synchronous, active low: degree 3, 4 points, every weight reads as 1.0.
// One request at a time; the result strobe comes in the last cycle that busy is high.
module rational_bspline_point_eval #(
  parameter int MAX_POINTS = rbspe_pkg::MAX_POINTS_DEF,
  parameter int MAX_DEGREE = rbspe_pkg::MAX_DEGREE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rbspe_pkg::in_req_t            in_req,
  output logic                          out_valid,
  output rbspe_pkg::out_res_t           out_res,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [rbspe_pkg::CFG_W-1:0]   cfg_wdata
);

  rbspe_pkg::dp_cmd_t cmd;
  rbspe_pkg::dp_sts_t sts;

  // Sequence each evaluate request: setup, basis levels, weighting, division
  rbspe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_req.kind),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold the point table, config, basis line, accumulators and divider
  rbspe_dp #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_res   (out_res)
  );

endmodule
